/* design/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/glzw_pkg.sv */
package glzw_pkg;
  localparam int DEF_MAX_CODES     = 4096;
  localparam int DEF_MAX_CODE_BITS = 12;

  localparam int NFC_W  = 13;
  localparam int CODE_W = 12;
  localparam int BUF_W  = 20;
  localparam int CNT_W  = 5;
  localparam int PIX_W  = 32;

  localparam logic [2:0] ST_PIXEL  = 3'd0;
  localparam logic [2:0] ST_NEED   = 3'd1;
  localparam logic [2:0] ST_ACCEPT = 3'd2;
  localparam logic [2:0] ST_DONE   = 3'd3;
  localparam logic [2:0] ST_ERROR  = 3'd4;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_PULL = 2'd1;
  localparam logic [1:0] OP_END  = 2'd2;

  localparam logic [1:0] CFG_MIN_SIZE = 2'd0;
  localparam logic [1:0] CFG_EXPECTED = 2'd1;

  localparam logic [3:0] MIN_SIZE_RESET = 4'd8;
  localparam logic [3:0] MIN_SIZE_LO    = 4'd2;
  localparam logic [3:0] MIN_SIZE_HI    = 4'd8;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] pixel;
    logic       last;
  } result_t;
endpackage

/* design/glzw_dict.sv */
module glzw_dict
  import glzw_pkg::*;
#(
  parameter int MAX_CODES = DEF_MAX_CODES,
  parameter int AW = $clog2(MAX_CODES)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [AW-1:0] wr_prefix,
  input  logic [7:0]    wr_suffix,
  input  logic [AW-1:0] rd_addr,
  output logic [AW-1:0] rd_prefix,
  output logic [7:0]    rd_suffix
);
  logic [AW-1:0] prefix_mem [MAX_CODES];
  logic [7:0]    suffix_mem [MAX_CODES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      prefix_mem[wr_addr] <= wr_prefix;
      suffix_mem[wr_addr] <= wr_suffix;
    end
    rd_prefix <= prefix_mem[rd_addr];
    rd_suffix <= suffix_mem[rd_addr];
  end
endmodule

/* design/glzw_stack.sv */
module glzw_stack
  import glzw_pkg::*;
#(
  parameter int MAX_CODES = DEF_MAX_CODES,
  parameter int AW = $clog2(MAX_CODES)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);
  logic [7:0] mem [MAX_CODES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

/* design/gif_lzw_decoder.sv */
// Channel | Dir | Payload
// in_     | in  | tuser: op[1:0]; tdata: data_byte[7:0]
// out_    | out | tuser: status[2:0]; tdata: pixel_index[7:0]; tlast: last_pixel
// cfg_    | in  | cfg_index selects register, cfg_data holds value
//
// One transaction at a time. Push, end and immediate error answers are accepted
// and then handed off; a pull from a loaded stack first reads the stack memory
// (S_POP, S_POPW). A pull on an empty stack fetches codes (S_FETCH), reads the
// dictionary per chain link (S_WALK, S_WAIT), takes the root (S_WALK), updates
// the dictionary (S_COMMIT). Sync active-low reset; memories need no clearing.
// The result register holds while out_tready is low; the next input transaction
// is taken once the result has moved to it.
module gif_lzw_decoder
  import glzw_pkg::*;
#(
  parameter int MAX_CODES     = DEF_MAX_CODES,
  parameter int MAX_CODE_BITS = DEF_MAX_CODE_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte[7:0]
  input  logic [1:0]  in_tuser,   // op[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // pixel_index[7:0]
  output logic [2:0]  out_tuser,  // status[2:0]
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int AW = $clog2(MAX_CODES);
  localparam int SW = AW + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FETCH  = 3'd1;
  localparam logic [2:0] S_WALK   = 3'd2;
  localparam logic [2:0] S_WAIT   = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;
  localparam logic [2:0] S_POP    = 3'd5;
  localparam logic [2:0] S_POPW   = 3'd6;
  localparam logic [2:0] S_FIN    = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [3:0]       min_r, min_nxt;
  logic [31:0]      exp_r, exp_nxt;
  logic [SW-1:0]    sc_r, sc_nxt;
  logic [BUF_W-1:0] buf_r, buf_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [3:0]       cw_r, cw_nxt;
  logic [NFC_W-1:0] nfc_r, nfc_nxt;
  logic [NFC_W-1:0] prev_r, prev_nxt;
  logic             pvalid_r, pvalid_nxt;
  logic [7:0]       pfirst_r, pfirst_nxt;
  logic [PIX_W-1:0] pix_r, pix_nxt;
  logic             ended_r, ended_nxt;
  logic             err_r, err_nxt;
  logic [NFC_W-1:0] cur_r, cur_nxt;
  logic [NFC_W-1:0] code_r, code_nxt;
  logic [SW-1:0]    n_r, n_nxt;
  logic [7:0]       first_r, first_nxt;
  result_t          res_r, res_nxt;
  result_t          out_r, out_nxt;
  logic             ov_r, ov_nxt;

  logic          d_we;
  logic [AW-1:0] d_waddr, d_wpre, d_raddr, d_rpre;
  logic [7:0]    d_wsuf, d_rsuf;
  logic          s_we;
  logic [AW-1:0] s_waddr, s_raddr;
  logic [7:0]    s_wdata, s_rdata;

  logic [NFC_W-1:0] clr_code;
  logic             size_ok;
  logic [BUF_W-1:0] code_mask;
  logic [NFC_W-1:0] code_now;
  logic [PIX_W:0]   pix_sum;

  glzw_dict #(.MAX_CODES(MAX_CODES), .AW(AW)) u_dict (
    .clk(clk), .wr_en(d_we), .wr_addr(d_waddr), .wr_prefix(d_wpre),
    .wr_suffix(d_wsuf), .rd_addr(d_raddr), .rd_prefix(d_rpre), .rd_suffix(d_rsuf)
  );

  glzw_stack #(.MAX_CODES(MAX_CODES), .AW(AW)) u_stack (
    .clk(clk), .wr_en(s_we), .wr_addr(s_waddr), .wr_data(s_wdata),
    .rd_addr(s_raddr), .rd_data(s_rdata)
  );

  assign clr_code   = NFC_W'(32'(1) << min_r);
  assign size_ok    = (min_r >= MIN_SIZE_LO) && (min_r <= MIN_SIZE_HI);
  assign code_mask  = (BUF_W'(1) << cw_r) - BUF_W'(1);
  assign code_now   = NFC_W'(buf_r & code_mask);
  assign pix_sum    = {1'b0, pix_r} + (PIX_W + 1)'(n_r);

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = ov_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = out_r.pixel;
  assign out_tlast  = out_r.last;

  always_comb begin
    state_nxt  = state_r;
    min_nxt    = min_r;
    exp_nxt    = exp_r;
    sc_nxt     = sc_r;
    buf_nxt    = buf_r;
    cnt_nxt    = cnt_r;
    cw_nxt     = cw_r;
    nfc_nxt    = nfc_r;
    prev_nxt   = prev_r;
    pvalid_nxt = pvalid_r;
    pfirst_nxt = pfirst_r;
    pix_nxt    = pix_r;
    ended_nxt  = ended_r;
    err_nxt    = err_r;
    cur_nxt    = cur_r;
    code_nxt   = code_r;
    n_nxt      = n_r;
    first_nxt  = first_r;
    res_nxt    = res_r;
    out_nxt    = out_r;
    ov_nxt     = ov_r;
    d_we       = 1'b0;
    d_waddr    = nfc_r[AW-1:0];
    d_wpre     = prev_r[AW-1:0];
    d_wsuf     = first_r;
    d_raddr    = cur_r[AW-1:0];
    s_we       = 1'b0;
    s_waddr    = n_r[AW-1:0];
    s_wdata    = cur_r[7:0];
    s_raddr    = sc_r[AW-1:0];

    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          res_nxt   = '{status: ST_ERROR, pixel: 8'd0, last: 1'b0};
          state_nxt = S_FIN;
          if (in_tuser != OP_PUSH && in_tuser != OP_PULL && in_tuser != OP_END) begin
            // unknown op: answer error, keep state
          end else if (err_r) begin
            // sticky
          end else if (!size_ok) begin
            err_nxt = 1'b1;
          end else if (ended_r) begin
            res_nxt.status = (in_tuser == OP_PUSH) ? ST_ACCEPT : ST_DONE;
          end else if (in_tuser == OP_PUSH) begin
            if (cnt_r > CNT_W'(12)) begin
              err_nxt = 1'b1;
            end else begin
              buf_nxt = buf_r | (BUF_W'(in_tdata) << cnt_r);
              cnt_nxt = cnt_r + CNT_W'(8);
              res_nxt.status = ST_ACCEPT;
            end
          end else if (in_tuser == OP_END) begin
            if (sc_r == '0 && pix_r == exp_r) begin
              ended_nxt = 1'b1;
              res_nxt.status = ST_DONE;
            end else begin
              err_nxt = 1'b1;
            end
          end else begin
            state_nxt = (sc_r != '0) ? S_POP : S_FETCH;
          end
        end
      end
      S_FETCH: begin
        if (cnt_r < CNT_W'(cw_r)) begin
          res_nxt.status = ST_NEED;
          state_nxt = S_FIN;
        end else begin
          buf_nxt = buf_r >> cw_r;
          cnt_nxt = cnt_r - CNT_W'(cw_r);
          if (code_now == clr_code) begin
            cw_nxt     = min_r + 4'd1;
            nfc_nxt    = NFC_W'((32'(1) << min_r) + 32'd2);
            pvalid_nxt = 1'b0;
            prev_nxt   = '0;
          end else if (code_now == clr_code + NFC_W'(1)) begin
            state_nxt = S_FIN;
            if (pix_r == exp_r) begin
              ended_nxt = 1'b1;
              res_nxt.status = ST_DONE;
            end else begin
              err_nxt = 1'b1;
            end
          end else if (code_now > nfc_r || code_now >= NFC_W'(MAX_CODES) ||
                       (code_now == nfc_r && !pvalid_r)) begin
            err_nxt   = 1'b1;
            state_nxt = S_FIN;
          end else begin
            code_nxt = code_now;
            if (code_now == nfc_r) begin
              // KwKwK: last char is first char of previous string
              s_we    = 1'b1;
              s_waddr = '0;
              s_wdata = pfirst_r;
              n_nxt   = SW'(1);
              cur_nxt = prev_r;
            end else begin
              n_nxt   = '0;
              cur_nxt = code_now;
            end
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (n_r >= SW'(MAX_CODES) || cur_r >= NFC_W'(MAX_CODES)) begin
          err_nxt   = 1'b1;
          state_nxt = S_FIN;
        end else if (cur_r < clr_code) begin
          s_we      = 1'b1;
          first_nxt = cur_r[7:0];
          n_nxt     = n_r + SW'(1);
          state_nxt = S_COMMIT;
        end else begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        s_we      = 1'b1;
        s_wdata   = d_rsuf;
        cur_nxt   = NFC_W'(d_rpre);
        n_nxt     = n_r + SW'(1);
        state_nxt = S_WALK;
      end
      S_COMMIT: begin
        if (pix_sum > {1'b0, exp_r}) begin
          err_nxt   = 1'b1;
          state_nxt = S_FIN;
        end else begin
          if (pvalid_r && nfc_r < NFC_W'(MAX_CODES)) begin
            d_we    = 1'b1;
            nfc_nxt = nfc_r + NFC_W'(1);
            if (cw_r < 4'(MAX_CODE_BITS) &&
                (nfc_r + NFC_W'(1)) == (NFC_W'(1) << cw_r)) begin
              cw_nxt = cw_r + 4'd1;
            end
          end
          prev_nxt   = code_r;
          pvalid_nxt = 1'b1;
          pfirst_nxt = first_r;
          sc_nxt     = n_r;
          pix_nxt    = pix_sum[PIX_W-1:0];
          state_nxt  = S_POP;
        end
      end
      S_POP: begin
        s_raddr   = sc_r[AW-1:0] - AW'(1);
        sc_nxt    = sc_r - SW'(1);
        state_nxt = S_POPW;
      end
      S_POPW: begin
        res_nxt   = '{status: ST_PIXEL, pixel: s_rdata,
                      last: (sc_r == '0) && (pix_r == exp_r)};
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!ov_r || out_tready) begin
          out_nxt   = res_r;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_valid) begin
      if (cfg_index == CFG_MIN_SIZE) begin
        min_nxt    = cfg_data[3:0];
        cw_nxt     = cfg_data[3:0] + 4'd1;
        nfc_nxt    = NFC_W'((32'(1) << cfg_data[3:0]) + 32'd2);
        pvalid_nxt = 1'b0;
        prev_nxt   = '0;
      end else if (cfg_index == CFG_EXPECTED) begin
        exp_nxt = cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      min_r    <= MIN_SIZE_RESET;
      exp_r    <= 32'd1;
      sc_r     <= '0;
      buf_r    <= '0;
      cnt_r    <= '0;
      cw_r     <= MIN_SIZE_RESET + 4'd1;
      nfc_r    <= NFC_W'((32'(1) << MIN_SIZE_RESET) + 32'd2);
      prev_r   <= '0;
      pvalid_r <= 1'b0;
      pfirst_r <= '0;
      pix_r    <= '0;
      ended_r  <= 1'b0;
      err_r    <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      min_r    <= min_nxt;
      exp_r    <= exp_nxt;
      sc_r     <= sc_nxt;
      buf_r    <= buf_nxt;
      cnt_r    <= cnt_nxt;
      cw_r     <= cw_nxt;
      nfc_r    <= nfc_nxt;
      prev_r   <= prev_nxt;
      pvalid_r <= pvalid_nxt;
      pfirst_r <= pfirst_nxt;
      pix_r    <= pix_nxt;
      ended_r  <= ended_nxt;
      err_r    <= err_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    code_r  <= code_nxt;
    n_r     <= n_nxt;
    first_r <= first_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end
endmodule

/* design/glzw_checker.sv */
`include "assert_macros.svh"

module glzw_checker
  import glzw_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [2:0] out_tuser,
  input logic       out_tlast
);
  `ASSERT_ALWAYS(a_status_range, clk, rst_n, !out_tvalid || out_tuser <= ST_ERROR)
  `ASSERT_ALWAYS(a_last_is_pixel, clk, rst_n, !(out_tvalid && out_tlast) || out_tuser == ST_PIXEL)
  `ASSERT_ALWAYS(a_idx_zero, clk, rst_n, !out_tvalid || out_tuser == ST_PIXEL || out_tdata == 8'd0)
  `ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tuser))
endmodule

bind gif_lzw_decoder glzw_checker u_glzw_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
);

/* tb/tb.sv */
`timescale 1ns / 1ps

// Testbench for gif_lzw_decoder.
// A frame generator builds a legal code stream (literals, dictionary hits, KwKwK
// codes, clear codes, width growth), packs it LSB first
// and schedules pushes and pulls so the bit buffer never overflows. The frame
// may end cleanly or with one of the error endings. Afterwards the block is
// driven past the end and through bad code sizes with random items.
// Every accepted input transaction runs through a local decoder model; each
// output transaction is checked against the oldest predicted answer.
module tb;
  import glzw_pkg::*;

  localparam logic [1:0] OP_BAD   = 2'd3;  // undefined op
  localparam int         DICT_MAX = 4096;
  localparam int         WDOG_MAX = 40000; // cycles without any transaction

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
  } cmd_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // data_byte[7:0]
  logic [1:0]  in_tuser = '0;   // op[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;      // pixel_index[7:0]
  logic [2:0]  out_tuser;      // status[2:0]
  logic        out_tlast;      // last_pixel
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  gif_lzw_decoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  cmd_t    cmd_q[$];     // items waiting for the driver
  result_t answer_q[$];  // predicted answers, oldest first
  int      fails = 0;

  // ---------------------------------------------------------------------------
  // Decoder model state
  // ---------------------------------------------------------------------------
  logic [11:0] m_prefix [DICT_MAX];
  logic [7:0]  m_suffix [DICT_MAX];
  logic [7:0]  m_stack  [DICT_MAX];
  int          m_depth;       // entries on the expansion stack
  logic [19:0] m_buf;
  int          m_bits;
  int          m_width;
  int          m_nfc;         // next free code
  int          m_prev;
  bit          m_prev_ok;
  logic [7:0]  m_first;       // first byte of previous string
  longint      m_pixels;
  bit          m_ended;
  bit          m_err;
  int          m_mcs;
  longint      m_expect;

  task automatic dict_restart();
    m_width   = (m_mcs + 1) & 15;
    m_nfc     = ((1 << m_mcs) + 2) & 13'h1fff;
    m_prev_ok = 1'b0;
    m_prev    = 0;
  endtask

  // Expand one data code onto the empty stack; ok=0 on any decode error.
  task automatic expand_code(input int code, output bit ok);
    int n;
    int cur;
    int clr;
    logic [7:0] first;
    bit deferred;
    ok  = 1'b0;
    clr = 1 << m_mcs;
    if (code > m_nfc || code >= DICT_MAX) return;
    deferred = (code == m_nfc);
    if (deferred && !m_prev_ok) return;
    n = 0;
    if (deferred) begin
      m_stack[0] = m_first;
      n = 1;
    end
    cur = deferred ? m_prev : code;
    forever begin
      if (n >= DICT_MAX || cur >= DICT_MAX) return;  // chain guard
      if (cur < clr) begin
        m_stack[n] = cur[7:0];
        n++;
        break;
      end
      m_stack[n] = m_suffix[cur];
      n++;
      cur = m_prefix[cur];
    end
    first = m_stack[n-1];
    if (m_pixels + n > m_expect) return;  // too many pixels
    if (m_prev_ok && m_nfc < DICT_MAX) begin
      m_prefix[m_nfc] = m_prev[11:0];
      m_suffix[m_nfc] = first;
      m_nfc++;
      if (m_width < 12 && m_nfc == (1 << m_width)) m_width++;
    end
    m_prev    = code;
    m_prev_ok = 1'b1;
    m_first   = first;
    m_depth   = n;
    m_pixels += n;
    ok = 1'b1;
  endtask

  task automatic decode_item(input logic [1:0] op, input logic [7:0] d, output result_t r);
    int code;
    int clr;
    bit ok;
    r = '0;
    r.status = ST_ERROR;
    if (op == OP_BAD) begin
      // answers error, state untouched
    end else if (m_err) begin
      // sticky error
    end else if (m_mcs < 2 || m_mcs > 8) begin
      m_err = 1'b1;
    end else if (m_ended) begin
      r.status = (op == OP_PUSH) ? ST_ACCEPT : ST_DONE;
    end else if (op == OP_PUSH) begin
      if (m_bits > 12) begin
        m_err = 1'b1;
      end else begin
        m_buf   = m_buf | (20'(d) << m_bits);
        m_bits += 8;
        r.status = ST_ACCEPT;
      end
    end else if (op == OP_END) begin
      if (m_depth == 0 && m_pixels == m_expect) begin
        m_ended  = 1'b1;
        r.status = ST_DONE;
      end else begin
        m_err = 1'b1;
      end
    end else begin
      clr = 1 << m_mcs;
      r.status = ST_PIXEL;
      while (m_depth == 0) begin
        if (m_bits < m_width) begin
          r.status = ST_NEED;
          break;
        end
        code    = int'(m_buf & ((20'd1 << m_width) - 20'd1));
        m_buf   = m_buf >> m_width;
        m_bits -= m_width;
        if (code == clr) begin
          dict_restart();
        end else if (code == clr + 1) begin
          if (m_pixels == m_expect) begin
            m_ended  = 1'b1;
            r.status = ST_DONE;
          end else begin
            m_err    = 1'b1;
            r.status = ST_ERROR;
          end
          break;
        end else begin
          expand_code(code, ok);
          if (!ok) begin
            m_err    = 1'b1;
            r.status = ST_ERROR;
            break;
          end
        end
      end
      if (r.status == ST_PIXEL) begin
        m_depth--;
        r.pixel = m_stack[m_depth & (DICT_MAX - 1)];
        r.last  = (m_depth == 0 && m_pixels == m_expect);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one item per transaction, with a random idle gap before each
  // ---------------------------------------------------------------------------
  int   tx_gap = 0;
  cmd_t tx_cur;

  always @(posedge clk) begin
    result_t r;
    bit      take;
    bit      nv;
    take = in_tvalid && in_tready;
    if (take) begin
      decode_item(in_tuser, in_tdata, r);
      answer_q.insert(answer_q.size(), r);
    end
    nv = in_tvalid && !take;
    if (rst_n && (!in_tvalid || take)) begin
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (cmd_q.size() > 0) begin
        tx_cur = cmd_q.pop_front();
        in_tuser <= tx_cur.op;
        in_tdata <= tx_cur.data;
        nv = 1'b1;
        tx_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      end
    end
    in_tvalid <= nv;
  end

  // ---------------------------------------------------------------------------
  // Monitor: random stall per result, one long hold-off so the block backs up
  // ---------------------------------------------------------------------------
  int rx_wait = 0;
  int rx_hold = 0;
  int rx_seen = 0;
  int idle_cycles = 0;

  always @(posedge clk) begin
    result_t e;
    bit      take;
    take = out_tvalid && out_tready;
    if (take) begin
      rx_seen++;
      if (answer_q.size() == 0) begin
        $error("unexpected result status=%0d pixel=%0d last=%0d",
               out_tuser, out_tdata, out_tlast);
        fails++;
      end else begin
        e = answer_q.pop_front();
        if (out_tuser !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_tuser);
          fails++;
        end
        if (out_tdata !== e.pixel) begin
          $error("pixel_index: expected %0d, got %0d", e.pixel, out_tdata);
          fails++;
        end
        if (out_tlast !== e.last) begin
          $error("last_pixel: expected %0d, got %0d", e.last, out_tlast);
          fails++;
        end
      end
      rx_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (rx_seen == 60) rx_hold = 400;
    end else begin
      if (rx_wait > 0) rx_wait--;
      if (rx_hold > 0) rx_hold--;
    end
    out_tready <= rst_n && rx_wait == 0 && rx_hold == 0;

    // watchdog on any handshake
    if (take || (in_tvalid && in_tready) || (cfg_valid && cfg_ready) || !rst_n) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WDOG_MAX) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Frame generator
  // ---------------------------------------------------------------------------
  int g_code[$];
  int g_wid[$];
  int g_len[$];
  int g_glen[DICT_MAX];
  int g_nfc, g_w, g_prev, g_mcs;
  bit g_prev_ok;
  longint g_total;

  task automatic add_cmd(input logic [1:0] op, input logic [7:0] d);
    cmd_t c;
    c.op   = op;
    c.data = d;
    cmd_q.insert(cmd_q.size(), c);
  endtask

  task automatic gen_code(input int c);
    int clr;
    int len;
    clr = 1 << g_mcs;
    g_code.insert(g_code.size(), c);
    g_wid.insert(g_wid.size(), g_w);
    len = 0;
    if (c == clr) begin
      g_w = g_mcs + 1;
      g_nfc = clr + 2;
      g_prev_ok = 1'b0;
    end else if (c != clr + 1) begin
      if (c < clr) len = 1;
      else if (c < g_nfc) len = g_glen[c];
      else len = g_glen[g_prev] + 1;  // KwKwK
      if (g_prev_ok && g_nfc < DICT_MAX) begin
        g_glen[g_nfc] = g_glen[g_prev] + 1;
        g_nfc++;
        if (g_w < 12 && g_nfc == (1 << g_w)) g_w++;
      end
      g_prev = c;
      g_prev_ok = 1'b1;
      g_total += len;
    end
    g_len.insert(g_len.size(), len);
  endtask

  // Wait until the driver is empty and every answer has arrived.
  task automatic drain();
    @(negedge clk);
    while (cmd_q.size() != 0 || in_tvalid || answer_q.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_MIN_SIZE) begin
      m_mcs = val[3:0];
      dict_restart();
    end else if (idx == CFG_EXPECTED) begin
      m_expect = val;
    end
  endtask

  initial begin
    int clr, c, r, variant, gb, bi, n_items, half;
    bit bitq[$];
    logic [7:0] bytes[$];
    logic [7:0] acc;
    cmd_t frame_q[$];
    cmd_t fc;
    longint expect_px;

    m_mcs = MIN_SIZE_RESET;
    m_expect = 1;
    m_depth = 0; m_buf = '0; m_bits = 0; m_first = '0; m_pixels = 0;
    m_ended = 1'b0; m_err = 1'b0;
    dict_restart();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: undefined op, pull on empty buffer, minimum pixel count
    add_cmd(OP_BAD, 8'hff);
    add_cmd(OP_PULL, 8'h00);
    add_cmd(OP_BAD, 8'h00);
    drain();
    cfg_write(CFG_EXPECTED, 32'd1);

    // build the frame's code list
    g_mcs = $urandom_range(MIN_SIZE_LO, MIN_SIZE_HI);
    if ($urandom_range(0, 3) == 0) g_mcs = ($urandom_range(0, 1) == 0) ? 2 : 8;
    clr = 1 << g_mcs;
    for (int k = 0; k < clr; k++) g_glen[k] = 1;  // literals expand to one pixel
    g_w = g_mcs + 1; g_nfc = clr + 2; g_prev_ok = 1'b0; g_prev = 0; g_total = 0;
    gen_code(clr);
    n_items = 0;
    while (n_items < 190) begin
      n_items++;
      if ($urandom_range(0, 59) == 0) begin
        gen_code(clr);
        continue;
      end
      r = $urandom_range(0, 99);
      if (r < 8 && g_prev_ok && g_nfc < DICT_MAX) c = g_nfc;
      else if (r < 28 && g_nfc > clr + 2) c = $urandom_range(clr + 2, g_nfc - 1);
      else c = $urandom_range(0, clr - 1);
      gen_code(c);
    end

    // frame ending: clean or one of the error endings, chosen at random
    variant = $urandom_range(0, 9);
    expect_px = g_total;
    case (variant)
      4: begin  // code beyond the dictionary
        if (g_nfc + 1 < (1 << g_w)) begin
          g_code.insert(g_code.size(), g_nfc + 1);
          g_wid.insert(g_wid.size(), g_w);
          g_len.insert(g_len.size(), 1);
        end else begin
          gen_code(clr + 1);
        end
      end
      5: begin  // expansion runs past the pixel count
        expect_px = g_total - 1;
        gen_code(clr + 1);
      end
      6: begin  // end code with pixels missing
        expect_px = g_total + 1;
        gen_code(clr + 1);
      end
      7, 8: ;   // end of data with stack loaded / buffer overflow, handled below
      9: begin  // deferred code right after a clear
        gen_code(clr);
        g_code.insert(g_code.size(), clr + 2);
        g_wid.insert(g_wid.size(), g_mcs + 1);
        g_len.insert(g_len.size(), 1);
      end
      default: gen_code(clr + 1);
    endcase

    // pack LSB first
    foreach (g_code[i])
      for (int b = 0; b < g_wid[i]; b++) bitq.insert(bitq.size(), (g_code[i] >> b) & 1);
    while (bitq.size() > 0) begin
      acc = '0;
      for (int b = 0; b < 8; b++) if (bitq.size() > 0) acc[b] = bitq.pop_front();
      bytes.insert(bytes.size(), acc);
    end

    // schedule pushes and pulls so bytes are pushed only as the next code needs them
    gb = 0;
    bi = 0;
    foreach (g_code[i]) begin
      while (gb < g_wid[i] && bi < bytes.size()) begin
        fc.op = OP_PUSH; fc.data = bytes[bi++];
        frame_q.insert(frame_q.size(), fc);
        gb += 8;
      end
      gb -= g_wid[i];
      fc.op = OP_PULL; fc.data = $urandom();
      if (g_code[i] == clr) begin
        // clear alone: a pull eats it and reports need data
        if (gb < g_mcs + 1) frame_q.insert(frame_q.size(), fc);
      end else if (g_code[i] == clr + 1 || g_len[i] == 0) begin
        frame_q.insert(frame_q.size(), fc);
      end else begin
        for (int k = 0; k < g_len[i]; k++) begin
          fc.data = $urandom();
          frame_q.insert(frame_q.size(), fc);
          if ($urandom_range(0, 99) < 2) begin
            fc.op = OP_BAD;
            frame_q.insert(frame_q.size(), fc);
            fc.op = OP_PULL;
          end
        end
      end
    end
    if (variant == 7) void'(frame_q.pop_back());
    if (variant == 8) begin
      for (int k = 0; k < 3; k++) begin
        fc.op = OP_PUSH; fc.data = $urandom();
        frame_q.insert(frame_q.size(), fc);
      end
    end

    cfg_write(CFG_MIN_SIZE, 32'(g_mcs));
    cfg_write(CFG_EXPECTED, expect_px[31:0]);

    // first half, a full pause, then the rest
    half = frame_q.size() / 2;
    for (int k = 0; k < half; k++) cmd_q.insert(cmd_q.size(), frame_q[k]);
    drain();
    for (int k = half; k < frame_q.size(); k++) cmd_q.insert(cmd_q.size(), frame_q[k]);

    // past the end: end of data, late pushes and pulls, undefined op
    add_cmd(OP_END, 8'h00);
    while (bi < bytes.size()) add_cmd(OP_PUSH, bytes[bi++]);
    add_cmd(OP_PUSH, 8'hff);
    add_cmd(OP_PULL, 8'h55);
    add_cmd(OP_END, 8'haa);
    add_cmd(OP_BAD, 8'h00);
    drain();

    // code size above the legal range
    cfg_write(CFG_MIN_SIZE, 32'd15);
    for (int k = 0; k < 20; k++) add_cmd($urandom_range(0, 3), $urandom());
    drain();

    // code size zero and the largest pixel count
    cfg_write(CFG_MIN_SIZE, 32'd0);
    cfg_write(CFG_EXPECTED, 32'hffff_ffff);
    for (int k = 0; k < 30; k++) add_cmd($urandom_range(0, 3), $urandom());
    drain();

    repeat (20) @(posedge clk);
    if (fails == 0 && answer_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
